// File: sv/bcu_pkg.sv
// Shared types, codes and condition logic for the branch condition unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package bcu_pkg;

  typedef enum logic [2:0] {
    ACT_BCC  = 3'd0,
    ACT_BRA  = 3'd1,
    ACT_BSR  = 3'd2,
    ACT_DBCC = 3'd3,
    ACT_JMP  = 3'd4,
    ACT_JSR  = 3'd5,
    ACT_RTS  = 3'd6,
    ACT_RTD  = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    CC_T  = 4'd0,
    CC_F  = 4'd1,
    CC_HI = 4'd2,
    CC_LS = 4'd3,
    CC_CC = 4'd4,
    CC_CS = 4'd5,
    CC_NE = 4'd6,
    CC_EQ = 4'd7,
    CC_VC = 4'd8,
    CC_VS = 4'd9,
    CC_PL = 4'd10,
    CC_MI = 4'd11,
    CC_GE = 4'd12,
    CC_LT = 4'd13,
    CC_GT = 4'd14,
    CC_LE = 4'd15
  } cond_t;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_V = 1;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_N = 3;

  localparam logic [7:0]  DISP_WORD = 8'h00;
  localparam logic [7:0]  DISP_LONG = 8'hFF;
  localparam logic [15:0] COUNT_END = 16'hFFFF;
  localparam logic [31:0] LONG_SIZE = 32'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] opcode;
    logic [31:0] extension;
    logic [4:0]  ccr;
    logic [31:0] pc_base;
    logic [31:0] sequential_pc;
    logic [15:0] counter_word;
    logic [31:0] stack_pointer;
    logic [31:0] jump_target;
    logic [31:0] popped_address;
  } cmd_word_t;

  typedef struct packed {
    logic [31:0] new_pc;
    logic        branch_taken;
    logic [15:0] counter_out;
    logic        counter_write;
    logic [31:0] new_sp;
    logic        push_write;
    logic [31:0] push_data;
  } res_word_t;

  function automatic logic cond_true(input logic [3:0] cc, input logic [4:0] ccr);
    logic c, v, z, n, r;
    c = ccr[FLAG_C];
    v = ccr[FLAG_V];
    z = ccr[FLAG_Z];
    n = ccr[FLAG_N];
    case (cond_t'(cc))
      CC_T:    r = 1'b1;
      CC_F:    r = 1'b0;
      CC_HI:   r = !c && !z;
      CC_LS:   r = c || z;
      CC_CC:   r = !c;
      CC_CS:   r = c;
      CC_NE:   r = !z;
      CC_EQ:   r = z;
      CC_VC:   r = !v;
      CC_VS:   r = v;
      CC_PL:   r = !n;
      CC_MI:   r = n;
      CC_GE:   r = (n == v);
      CC_LT:   r = (n != v);
      CC_GT:   r = !z && (n == v);
      CC_LE:   r = z || (n != v);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/bcu_resolve.sv
// Combinational resolution of one control instruction word into a result word.
// Depends on bcu_pkg for the word types, action codes and condition function.
`default_nettype none
module bcu_resolve (
  input  wire bcu_pkg::cmd_word_t cmd,
  output bcu_pkg::res_word_t res
);
  import bcu_pkg::*;

  logic [31:0] disp_word;
  logic [31:0] disp_byte;
  logic [31:0] disp;
  logic [31:0] target;
  logic        cond;
  logic [15:0] count_dec;
  logic [31:0] sp_up;

  assign disp_word = {{16{cmd.extension[15]}}, cmd.extension[15:0]};
  assign disp_byte = {{24{cmd.opcode[7]}}, cmd.opcode[7:0]};
  assign cond      = cond_true(cmd.opcode[11:8], cmd.ccr);
  assign count_dec = cmd.counter_word - 16'd1;
  assign sp_up     = cmd.stack_pointer + LONG_SIZE;

  always_comb begin
    if (action_t'(cmd.action) == ACT_DBCC || cmd.opcode[7:0] == DISP_WORD) begin
      disp = disp_word;
    end else if (cmd.opcode[7:0] == DISP_LONG) begin
      disp = cmd.extension;
    end else begin
      disp = disp_byte;
    end
  end

  assign target = cmd.pc_base + disp;

  always_comb begin
    res = '0;
    res.new_pc = cmd.sequential_pc;
    res.new_sp = cmd.stack_pointer;
    case (action_t'(cmd.action))
      ACT_BCC: begin
        if (cond) begin
          res.new_pc       = target;
          res.branch_taken = 1'b1;
        end
      end
      ACT_BRA: begin
        res.new_pc       = target;
        res.branch_taken = 1'b1;
      end
      ACT_BSR: begin
        res.new_pc       = target;
        res.branch_taken = 1'b1;
        res.new_sp       = cmd.stack_pointer - LONG_SIZE;
        res.push_write   = 1'b1;
        res.push_data    = cmd.sequential_pc;
      end
      ACT_DBCC: begin
        if (!cond) begin
          res.counter_out   = count_dec;
          res.counter_write = 1'b1;
          if (count_dec != COUNT_END) begin
            res.new_pc       = target;
            res.branch_taken = 1'b1;
          end
        end
      end
      ACT_JMP: begin
        res.new_pc       = cmd.jump_target;
        res.branch_taken = 1'b1;
      end
      ACT_JSR: begin
        res.new_pc       = cmd.jump_target;
        res.branch_taken = 1'b1;
        res.new_sp       = cmd.stack_pointer - LONG_SIZE;
        res.push_write   = 1'b1;
        res.push_data    = cmd.sequential_pc;
      end
      ACT_RTS: begin
        res.new_pc       = cmd.popped_address;
        res.branch_taken = 1'b1;
        res.new_sp       = sp_up;
      end
      default: begin
        res.new_pc       = cmd.popped_address;
        res.branch_taken = 1'b1;
        res.new_sp       = sp_up + disp_word;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/branch_condition_unit.sv
// Branch condition unit: top level with input register and result register.
// Depends on bcu_pkg and bcu_resolve.
// Commands pass through the input register, then the result register.
// Throughput: one word per cycle unless res_ready stalls; both form a two-entry pipeline.
// Reset: synchronous, active high; clears both valid flags, payload is not reset.
`default_nettype none
module branch_condition_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                cmd_valid,
  output logic               cmd_ready,
  input  wire bcu_pkg::cmd_word_t cmd,
  output logic               res_valid,
  input  wire                res_ready,
  output bcu_pkg::res_word_t res
);
  import bcu_pkg::*;

  cmd_word_t stage_word;
  logic      stage_valid;
  res_word_t resolved;
  logic      advance;

  assign advance   = !res_valid || res_ready;
  assign cmd_ready = !stage_valid || advance;

  bcu_resolve u_resolve (
    .cmd (stage_word),
    .res (resolved)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd_ready) begin
      stage_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      stage_word <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      res <= resolved;
    end
  end

endmodule
`default_nettype wire

// File: sv/bcu_checker.sv
// Port-level assertions for the branch condition unit, bound to the top level.
// Depends on bcu_pkg for the result word type.
`default_nettype none
module bcu_checker (
  input wire                clk,
  input wire                rst,
  input wire                cmd_ready,
  input wire                res_valid,
  input wire                res_ready,
  input wire bcu_pkg::res_word_t res
);
  import bcu_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && cmd_ready)
    else $error("pipeline not empty after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result word changed");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.counter_write |-> res.counter_out == 16'd0)
    else $error("counter_out set without counter_write");

  a_push_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.push_write |-> res.push_data == 32'd0)
    else $error("push_data set without push_write");

  a_push_taken: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.push_write |-> res.branch_taken)
    else $error("push without taken branch");

endmodule

bind branch_condition_unit bcu_checker u_bcu_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
`default_nettype wire

// File: tb/bcu_tb_pkg.sv
`timescale 1ns / 1ps
// Result predictor and scoreboard for the branch condition unit testbench.
// Depends on bcu_pkg for the command and result word types and the codes.
package bcu_tb_pkg;
  import bcu_pkg::*;

  class branch_scoreboard;
    res_word_t   outcome_q[$];
    int unsigned mismatches;
    int unsigned words_in;
    int unsigned results_seen;
    int unsigned taken_seen;
    int unsigned counter_writes;
    int unsigned pushes;

    // Odd condition codes are the complement of the even code below them.
    function bit cond_holds(logic [3:0] cc, logic [4:0] flags);
      bit c, v, z, n, hold;
      c = flags[FLAG_C];
      v = flags[FLAG_V];
      z = flags[FLAG_Z];
      n = flags[FLAG_N];
      case (cond_t'({cc[3:1], 1'b0}))
        CC_T:    hold = 1'b1;
        CC_HI:   hold = !c && !z;
        CC_CC:   hold = !c;
        CC_NE:   hold = !z;
        CC_VC:   hold = !v;
        CC_PL:   hold = !n;
        CC_GE:   hold = (n == v);
        CC_GT:   hold = !z && (n == v);
        default: hold = 1'b0;
      endcase
      return hold ^ cc[0];
    endfunction

    function logic [31:0] word_disp(logic [31:0] ext);
      return {{16{ext[15]}}, ext[15:0]};
    endfunction

    function logic [31:0] branch_offset(logic [7:0] low, logic [31:0] ext);
      if (low == DISP_WORD) return word_disp(ext);
      if (low == DISP_LONG) return ext;
      return {{24{low[7]}}, low};
    endfunction

    function res_word_t resolve(cmd_word_t w);
      res_word_t   r;
      logic [15:0] count;
      logic [31:0] target;
      r = '0;
      r.new_pc = w.sequential_pc;
      r.new_sp = w.stack_pointer;
      target = w.pc_base + branch_offset(w.opcode[7:0], w.extension);
      case (action_t'(w.action))
        ACT_BCC: begin
          if (cond_holds(w.opcode[11:8], w.ccr)) begin
            r.new_pc = target;
            r.branch_taken = 1'b1;
          end
        end
        ACT_BRA: begin
          r.new_pc = target;
          r.branch_taken = 1'b1;
        end
        ACT_BSR: begin
          r.new_pc = target;
          r.branch_taken = 1'b1;
          r.new_sp = w.stack_pointer - LONG_SIZE;
          r.push_write = 1'b1;
          r.push_data = w.sequential_pc;
        end
        ACT_DBCC: begin
          if (!cond_holds(w.opcode[11:8], w.ccr)) begin
            count = w.counter_word - 16'd1;
            r.counter_out = count;
            r.counter_write = 1'b1;
            if (count != COUNT_END) begin
              r.new_pc = w.pc_base + word_disp(w.extension);
              r.branch_taken = 1'b1;
            end
          end
        end
        ACT_JMP: begin
          r.new_pc = w.jump_target;
          r.branch_taken = 1'b1;
        end
        ACT_JSR: begin
          r.new_pc = w.jump_target;
          r.branch_taken = 1'b1;
          r.new_sp = w.stack_pointer - LONG_SIZE;
          r.push_write = 1'b1;
          r.push_data = w.sequential_pc;
        end
        ACT_RTS: begin
          r.new_pc = w.popped_address;
          r.branch_taken = 1'b1;
          r.new_sp = w.stack_pointer + LONG_SIZE;
        end
        default: begin
          r.new_pc = w.popped_address;
          r.branch_taken = 1'b1;
          r.new_sp = w.stack_pointer + LONG_SIZE + word_disp(w.extension);
        end
      endcase
      return r;
    endfunction

    function void note_command(cmd_word_t w);
      res_word_t r;
      r = resolve(w);
      words_in++;
      taken_seen += r.branch_taken;
      counter_writes += r.counter_write;
      pushes += r.push_write;
      outcome_q.push_back(r);
    endfunction

    function void check_result(res_word_t got);
      res_word_t want;
      bit        bad;
      results_seen++;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word pc=%h sp=%h", got.new_pc, got.new_sp);
        return;
      end
      want = outcome_q.pop_front();
      bad = (got.new_pc !== want.new_pc) || (got.branch_taken !== want.branch_taken) ||
            (got.counter_out !== want.counter_out) ||
            (got.counter_write !== want.counter_write) ||
            (got.new_sp !== want.new_sp) || (got.push_write !== want.push_write) ||
            (got.push_data !== want.push_data);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d", results_seen);
          $display("  got      pc=%h tk=%b cnt=%h cw=%b sp=%h pw=%b pd=%h",
                   got.new_pc, got.branch_taken, got.counter_out, got.counter_write,
                   got.new_sp, got.push_write, got.push_data);
          $display("  expected pc=%h tk=%b cnt=%h cw=%b sp=%h pw=%b pd=%h",
                   want.new_pc, want.branch_taken, want.counter_out, want.counter_write,
                   want.new_sp, want.push_write, want.push_data);
        end
      end
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for branch_condition_unit: drives control instruction words,
// predicts each result word and checks it. Depends on bcu_pkg and bcu_tb_pkg.
module tb_top;
  import bcu_pkg::*;
  import bcu_tb_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_word_t cmd = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_word_t res;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  branch_scoreboard sb = new();

  branch_condition_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) sb.note_command(cmd);
      if (res_valid && res_ready) sb.check_result(res);
    end
  end

  initial begin
    #4_800_000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_word(input cmd_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // hold off new words until every outstanding result has come back
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic cmd_word_t make_word(action_t a, cond_t c, logic [7:0] disp);
    cmd_word_t w;
    w.action = a;
    w.opcode = 16'($urandom);
    w.opcode[11:8] = c;
    w.opcode[7:0] = disp;
    w.extension = $urandom;
    w.ccr = 5'($urandom);
    w.pc_base = $urandom;
    w.sequential_pc = $urandom;
    w.counter_word = 16'($urandom);
    w.stack_pointer = $urandom;
    w.jump_target = $urandom;
    w.popped_address = $urandom;
    return w;
  endfunction

  function automatic cmd_word_t random_word();
    cmd_word_t  w;
    logic [7:0] disp;
    case ($urandom_range(0, 5))
      0:       disp = DISP_WORD;
      1:       disp = DISP_LONG;
      default: disp = 8'($urandom);
    endcase
    w = make_word(action_t'($urandom_range(0, 7)), cond_t'($urandom_range(0, 15)), disp);
    case ($urandom_range(0, 3))
      0: w.counter_word = 16'h0000;
      1: w.counter_word = 16'h0001;
      default: ;
    endcase
    return w;
  endfunction

  task automatic directed_words();
    cmd_word_t w;
    w = '0;
    send_word(w);
    w = '1;
    send_word(w);
    w = make_word(ACT_BCC, CC_T, 8'h7E);
    send_word(w);
    w = make_word(ACT_BCC, CC_T, 8'h80);
    send_word(w);
    w = make_word(ACT_BCC, CC_T, DISP_WORD);
    w.extension = 32'h1234_8000;
    send_word(w);
    w = make_word(ACT_BCC, CC_T, DISP_LONG);
    w.extension = 32'h8000_0002;
    send_word(w);
    w = make_word(ACT_BCC, CC_EQ, 8'h10);
    w.ccr = 5'b11011;
    send_word(w);
    w = make_word(ACT_BCC, CC_T, 8'h10);
    w.pc_base = 32'hFFFF_FFFE;
    send_word(w);
    w = make_word(ACT_BRA, CC_F, 8'h22);
    send_word(w);
    w = make_word(ACT_BSR, CC_F, 8'hF0);
    w.stack_pointer = 32'h0000_0000;
    send_word(w);
    w = make_word(ACT_DBCC, CC_T, 8'h00);
    send_word(w);
    w = make_word(ACT_DBCC, CC_F, 8'h00);
    w.counter_word = 16'h0000;
    send_word(w);
    w = make_word(ACT_DBCC, CC_F, 8'h00);
    w.counter_word = 16'h0001;
    send_word(w);
    w = make_word(ACT_DBCC, CC_F, 8'h00);
    w.counter_word = 16'h8000;
    w.extension = 32'h0000_FFFC;
    send_word(w);
    w = make_word(ACT_JMP, CC_T, 8'h00);
    send_word(w);
    w = make_word(ACT_JSR, CC_T, 8'h00);
    w.stack_pointer = 32'h0000_0002;
    send_word(w);
    w = make_word(ACT_RTS, CC_T, 8'h00);
    w.stack_pointer = 32'hFFFF_FFFC;
    send_word(w);
    w = make_word(ACT_RTD, CC_T, 8'h00);
    w.extension = 32'hFFFF_7FFF;
    send_word(w);
    w = make_word(ACT_RTD, CC_T, 8'h00);
    w.extension = 32'h0000_8000;
    send_word(w);
  endtask

  task automatic random_words(input int unsigned count);
    repeat (count) send_word(random_word());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 85;
    directed_words();
    random_words(510);
    drain();
    send_idle_pct = 85;
    recv_idle_pct = 27;
    random_words(510);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_words(510);
    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d control words through all eight actions and sixteen conditions:",
             sb.words_in);
    $display("%0d taken, %0d counter write-backs, %0d pushes, %0d mismatches",
             sb.taken_seen, sb.counter_writes, sb.pushes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: branch_condition_unit.f
sv/bcu_pkg.sv
sv/bcu_resolve.sv
sv/branch_condition_unit.sv
sv/bcu_checker.sv
tb/bcu_tb_pkg.sv
tb/tb_top.sv
